>>> design/mrf_pkg.sv
`default_nettype none

package mrf_pkg;

    localparam int CFG_W  = 5;
    localparam int ACT_W  = 2;
    localparam int ID_W   = 2;
    localparam int DATA_W = 64;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 4;
    localparam int CNT_W  = 32;

    localparam logic [CFG_W-1:0] CFG_SIZE_RST = 5'd16;

    localparam logic [ACT_W-1:0] ACT_ENQ = 2'd0;
    localparam logic [ACT_W-1:0] ACT_DEQ = 2'd1;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_META,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

>>> design/multi_ring_fifo_with_stats.sv
// Several ring fifos sharing one element memory; each word picks a ring.
// Input channel: i_valid / o_ready with i_action (0 enqueue, 1 dequeue,
// else query), i_ring_id and i_write_data. Output channel: o_valid / i_ready,
// one result word per input word: status, dequeued data, occupancy and the
// ring's failed enqueue / dequeue counts.
// A ring holds ring_size - 1 elements; ring_size is written on i_cfg_we and
// is clamped to 2..RING_DEPTH. The user must write it only while the block is
// idle; the block itself does not enforce this. A word's ring state memory is
// read when the word is accepted, then the element memory is read alongside
// the ring state write-back, and the result is then shown on o_valid. One word
// is in flight at a time, so the block takes no new word until the receiver
// has taken the result.
// While i_ready is low the result holds on the outputs and o_ready stays low.
// Reset clears the state machine and the per-ring valid bits, so every ring
// starts empty with zero counters; ring_size returns to 16. The element
// memory is not cleared.
`default_nettype none

module multi_ring_fifo_with_stats
    import mrf_pkg::*;
#(
    parameter int NUM_RINGS  = 4,
    parameter int RING_DEPTH = 16,
    parameter int ELEM_BITS  = 64
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire [CFG_W-1:0]     i_cfg_data,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire [ACT_W-1:0]     i_action,
    input  wire [ID_W-1:0]      i_ring_id,
    input  wire [DATA_W-1:0]    i_write_data,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [STAT_W-1:0]   o_status,
    output logic [DATA_W-1:0]   o_read_data,
    output logic [OCC_W-1:0]    o_occupancy,
    output logic [CNT_W-1:0]    o_write_fail_count,
    output logic [CNT_W-1:0]    o_read_fail_count
);

    localparam int RING_W      = (NUM_RINGS > 1) ? $clog2(NUM_RINGS) : 1;
    localparam int IDX_W       = $clog2(RING_DEPTH);
    localparam int SZ_W        = $clog2(RING_DEPTH + 1);
    localparam int NX_W        = SZ_W + 1;
    localparam int STORE_DEPTH = NUM_RINGS * RING_DEPTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    typedef struct packed {
        logic [IDX_W-1:0] wr_idx;
        logic [IDX_W-1:0] rd_idx;
        logic [OCC_W-1:0] occ;
        logic [CNT_W-1:0] wfail;
        logic [CNT_W-1:0] rfail;
    } t_ring_meta;

    t_state r_state, n_state;

    logic [CFG_W-1:0]     r_ring_size;
    logic [NUM_RINGS-1:0] r_meta_vld;
    t_ring_meta           r_meta_mem [NUM_RINGS];
    logic [ELEM_BITS-1:0] r_elem_mem [STORE_DEPTH];

    t_ring_meta           r_meta_q;
    logic                 r_meta_vld_q;
    logic [ELEM_BITS-1:0] r_elem_q;

    logic [ACT_W-1:0]     r_action;
    logic [RING_W-1:0]    r_ring;
    logic                 r_id_ok;
    logic [ELEM_BITS-1:0] r_wdata;

    logic [STAT_W-1:0]    r_status;
    logic [OCC_W-1:0]     r_occ;
    logic [CNT_W-1:0]     r_wfail;
    logic [CNT_W-1:0]     r_rfail;
    logic                 r_deq_ok;

    logic in_acc;
    logic in_stage;
    logic meta_we;
    logic elem_we;
    logic elem_re;
    logic enq_ok;
    logic deq_ok;

    logic [RING_W-1:0] acc_ring;
    logic [SZ_W-1:0]   size;
    t_ring_meta        meta;
    t_ring_meta        n_meta;
    logic [NX_W-1:0]   w_nx;
    logic [NX_W-1:0]   r_nx;
    logic              full;
    logic              empty;
    logic [ADDR_W-1:0] elem_addr;
    logic [STAT_W-1:0] n_status;

    // fsm: next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_valid) n_state = S_META;
            S_META: n_state = S_OUT;
            S_OUT:  if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // fsm: outputs
    always_comb begin
        o_ready  = 1'b0;
        o_valid  = 1'b0;
        in_stage = 1'b0;
        case (r_state)
            S_IDLE: o_ready = 1'b1;
            S_META: in_stage = 1'b1;
            S_OUT:  o_valid = 1'b1;
            default: o_ready = 1'b0;
        endcase
    end

    assign in_acc   = i_valid && o_ready;
    assign acc_ring = RING_W'(i_ring_id);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ring_size <= CFG_SIZE_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_ring_size <= i_cfg_data;
            end
        end
    end

    // clamp ring size into 2..RING_DEPTH
    always_comb begin
        if (32'(r_ring_size) > 32'(RING_DEPTH)) begin
            size = SZ_W'(RING_DEPTH);
        end else if (r_ring_size < 5'd2) begin
            size = SZ_W'(2);
        end else begin
            size = SZ_W'(r_ring_size);
        end
    end

    // capture the word and read its ring state
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_action     <= i_action;
            r_ring       <= acc_ring;
            r_id_ok      <= (32'(i_ring_id) < 32'(NUM_RINGS));
            r_wdata      <= i_write_data[ELEM_BITS-1:0];
            r_meta_q     <= r_meta_mem[acc_ring];
            r_meta_vld_q <= r_meta_vld[acc_ring];
        end
    end

    assign meta = r_meta_vld_q ? r_meta_q : '0;

    always_comb begin
        w_nx  = NX_W'(meta.wr_idx) + NX_W'(1);
        r_nx  = NX_W'(meta.rd_idx) + NX_W'(1);
        full  = (w_nx == NX_W'(meta.rd_idx))
             || (w_nx == NX_W'(meta.rd_idx) + NX_W'(size))
             || (w_nx > NX_W'(size));
        empty = (meta.rd_idx == meta.wr_idx);
    end

    always_comb begin
        n_meta   = meta;
        n_status = ST_OK;
        enq_ok   = 1'b0;
        deq_ok   = 1'b0;
        case (r_action)
            ACT_ENQ: begin
                if (full) begin
                    n_meta.wfail = meta.wfail + CNT_W'(1);
                    n_status     = ST_FULL;
                end else begin
                    enq_ok        = 1'b1;
                    n_meta.wr_idx = (w_nx >= NX_W'(size)) ? '0 : IDX_W'(w_nx);
                    n_meta.occ    = meta.occ + OCC_W'(1);
                end
            end
            ACT_DEQ: begin
                if (empty) begin
                    n_meta.rfail = meta.rfail + CNT_W'(1);
                    n_status     = ST_EMPTY;
                end else begin
                    deq_ok        = 1'b1;
                    n_meta.rd_idx = (r_nx >= NX_W'(size)) ? '0 : IDX_W'(r_nx);
                    n_meta.occ    = meta.occ - OCC_W'(1);
                end
            end
            default: n_status = ST_OK;
        endcase
    end

    assign meta_we = in_stage && r_id_ok;
    assign elem_we = meta_we && enq_ok;
    assign elem_re = meta_we && deq_ok;

    always_comb begin
        if (r_action == ACT_ENQ) begin
            elem_addr = ADDR_W'(r_ring) * ADDR_W'(RING_DEPTH) + ADDR_W'(meta.wr_idx);
        end else begin
            elem_addr = ADDR_W'(r_ring) * ADDR_W'(RING_DEPTH) + ADDR_W'(meta.rd_idx);
        end
    end

    // ring state write-back
    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            r_meta_mem[r_ring] <= n_meta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_meta_vld <= '0;
        end else if (meta_we) begin
            r_meta_vld[r_ring] <= 1'b1;
        end
    end

    // element memory, one port used per word
    always_ff @(posedge i_clk) begin
        if (elem_we) begin
            r_elem_mem[elem_addr] <= r_wdata;
        end
        if (elem_re) begin
            r_elem_q <= r_elem_mem[elem_addr];
        end
    end

    // result word, unknown ring answers all zero
    always_ff @(posedge i_clk) begin
        if (in_stage) begin
            if (r_id_ok) begin
                r_status <= n_status;
                r_occ    <= n_meta.occ;
                r_wfail  <= n_meta.wfail;
                r_rfail  <= n_meta.rfail;
                r_deq_ok <= deq_ok;
            end else begin
                r_status <= ST_OK;
                r_occ    <= '0;
                r_wfail  <= '0;
                r_rfail  <= '0;
                r_deq_ok <= 1'b0;
            end
        end
    end

    assign o_status           = r_status;
    assign o_read_data        = r_deq_ok ? DATA_W'(r_elem_q) : '0;
    assign o_occupancy        = r_occ;
    assign o_write_fail_count = r_wfail;
    assign o_read_fail_count  = r_rfail;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input and output sides open at once");

    a_mem_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(elem_we && elem_re))
        else $error("element memory read and write in one cycle");

    a_meta_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_META |=> o_valid)
        else $error("result not presented after ring state update");

    a_fail_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_OK |-> o_read_data == '0)
        else $error("failed word carries read data");

    a_deq_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) && r_deq_ok |-> $past(elem_re))
        else $error("dequeue result without element read");

endmodule

`default_nettype wire
